// ----- rtl/core/pgf_pkg.sv -----
// Shared widths, register indexes and word types for the pairwise gravity force block.
package pgf_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // squared distance, square root and the products that feed the dividers
  localparam int SQ_W    = 2 * WORD_WIDTH + 2;
  localparam int ROOT_W  = WORD_WIDTH + 1;
  localparam int REM_S_W = ROOT_W + 2;
  localparam int DSQ_W   = SQ_W - FRAC_BITS;
  localparam int PROD_W  = 3 * WORD_WIDTH;
  localparam int DEN_W   = WORD_WIDTH + FRAC_BITS;
  localparam int MAG_W   = 2 * WORD_WIDTH;
  localparam int FQ_W    = WORD_WIDTH + 1;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DSQ  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DSQ  = 2'd2;

  localparam logic [WORD_WIDTH-1:0] ONE_FIX = WORD_WIDTH'(1) << FRAC_BITS;

  typedef struct packed {
    logic signed [WORD_WIDTH-1:0] first_pos_x;
    logic signed [WORD_WIDTH-1:0] first_pos_y;
    logic signed [WORD_WIDTH-1:0] second_pos_x;
    logic signed [WORD_WIDTH-1:0] second_pos_y;
    logic        [WORD_WIDTH-1:0] first_mass;
    logic        [WORD_WIDTH-1:0] second_mass;
  } pair_t;

  typedef struct packed {
    logic signed [WORD_WIDTH-1:0] force_x;
    logic signed [WORD_WIDTH-1:0] force_y;
    logic                         saturated;
  } force_t;

endpackage

// ----- rtl/core/pgf_if.sv -----
// Valid/ready channel interfaces for particle pair words and force words.
interface pgf_in_if import pgf_pkg::*; ();
  logic  valid;
  logic  ready;
  pair_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface pgf_out_if import pgf_pkg::*; ();
  logic   valid;
  logic   ready;
  force_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/pairwise_gravity_force.sv -----
// Top level: streaming 2D gravity force between two particles, Q16.16 fixed point.
//
// in_i carries one particle pair word (positions signed, masses unsigned),
// out_o one force word (force_x, force_y, saturated flag), valid/ready on both.
// cfg_we_i/cfg_idx_i/cfg_data_i write G and the squared distance clamp
// bounds; write them only while no pair is in flight.
//
// Throughput: one pair per cycle while the output buffer is not full.
// The register chains: the square root chain yields one root bit per
// cell, the magnitude divider and the two component dividers one
// quotient bit per cell.
//
// Reset clears the pipeline valid line and the two-word output buffer and
// loads the register defaults. When the receiver stalls, the pipeline keeps
// moving until the output buffer holds two words, then freezes as a whole
// and ready drops; it resumes the cycle after a word is taken.
module pairwise_gravity_force
  import pgf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [WORD_WIDTH-1:0] cfg_data_i,
  pgf_in_if.sink                in_i,
  pgf_out_if.source             out_o
);

  localparam int W   = WORD_WIDTH;
  localparam int LAT = 5 + ROOT_W + MAG_W + 3 + FQ_W;
  localparam int HI_W = PROD_W - FQ_W;

  typedef struct packed {
    logic [W-1:0] ux;
    logic [W-1:0] uy;
    logic         nx;
    logic         ny;
  } diff_t;

  typedef struct packed {
    logic [PROD_W-1:0] p;
    logic [DEN_W-1:0]  d;
    diff_t             dd;
    logic              zero;
  } sq_side_t;

  typedef struct packed {
    logic [ROOT_W-1:0] len;
    diff_t             dd;
    logic              zero;
    logic              movf;
  } mag_side_t;

  localparam int SQS_W = $bits(sq_side_t);
  localparam int MGS_W = $bits(mag_side_t);

  localparam logic [FQ_W-1:0] POS_LIM = {2'b00, {(W-1){1'b1}}};
  localparam logic [FQ_W-1:0] NEG_LIM = {2'b01, {(W-1){1'b0}}};
  localparam logic [W-1:0]    POS_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]    NEG_MIN = {1'b1, {(W-1){1'b0}}};

  // ---------------- configuration registers
  logic [W-1:0] grav_q, min_q, max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q <= ONE_FIX;
      min_q  <= ONE_FIX;
      max_q  <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GRAVITY: grav_q <= cfg_data_i;
        REG_MIN_DSQ: min_q  <= cfg_data_i;
        REG_MAX_DSQ: max_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- global advance and valid line
  logic [1:0]     cnt_q;
  logic           en;
  logic [LAT-1:0] vld_q;

  assign en         = (cnt_q != 2'd2);
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_i.valid};
    end
  end

  // ---------------- front end: differences, squares, mass product
  pair_t         pair1_q;
  logic [W:0]    dx_w, dy_w;
  diff_t         diff_d;
  diff_t         dd2_q, dd3_q, dd4_q, dd5_q;
  logic [MAG_W-1:0] mm2_q, sx3_q, sy3_q, pl3_q, ph3_q;
  logic [SQ_W-1:0]  s4_q, s5_q;
  logic [PROD_W-1:0] p4_q, p5_q;
  logic [DEN_W-1:0]  d5_q;
  logic              zero5_q;
  logic [DSQ_W-1:0]  dsq;
  logic [W-1:0]      clamp;

  always_comb begin
    dx_w = {pair1_q.second_pos_x[W-1], pair1_q.second_pos_x}
         - {pair1_q.first_pos_x[W-1], pair1_q.first_pos_x};
    dy_w = {pair1_q.second_pos_y[W-1], pair1_q.second_pos_y}
         - {pair1_q.first_pos_y[W-1], pair1_q.first_pos_y};
    diff_d.nx = dx_w[W];
    diff_d.ny = dy_w[W];
    diff_d.ux = dx_w[W] ? W'(~dx_w + 1'b1) : dx_w[W-1:0];
    diff_d.uy = dy_w[W] ? W'(~dy_w + 1'b1) : dy_w[W-1:0];
  end

  // clamp of the squared distance; when the bounds cross, min applies below min and max otherwise
  always_comb begin
    dsq = s4_q[SQ_W-1:FRAC_BITS];
    if (!(|dsq[DSQ_W-1:W]) && dsq[W-1:0] < min_q) begin
      clamp = min_q;
    end else if ((|dsq[DSQ_W-1:W]) || dsq[W-1:0] > max_q) begin
      clamp = max_q;
    end else begin
      clamp = dsq[W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pair1_q <= in_i.payload;
      dd2_q   <= diff_d;
      mm2_q   <= pair1_q.first_mass * pair1_q.second_mass;
      dd3_q   <= dd2_q;
      sx3_q   <= dd2_q.ux * dd2_q.ux;
      sy3_q   <= dd2_q.uy * dd2_q.uy;
      pl3_q   <= mm2_q[W-1:0] * grav_q;
      ph3_q   <= mm2_q[MAG_W-1:W] * grav_q;
      dd4_q   <= dd3_q;
      s4_q    <= SQ_W'(sx3_q) + SQ_W'(sy3_q);
      p4_q    <= PROD_W'(pl3_q) + {ph3_q, {W{1'b0}}};
      dd5_q   <= dd4_q;
      s5_q    <= s4_q;
      p5_q    <= p4_q;
      d5_q    <= {clamp, {FRAC_BITS{1'b0}}};
      zero5_q <= (s4_q == '0);
    end
  end

  // ---------------- square root chain: len = floor(sqrt(s))
  logic [REM_S_W-1:0] sq_rem  [ROOT_W+1];
  logic [SQ_W-1:0]    sq_rad  [ROOT_W+1];
  logic [ROOT_W-1:0]  sq_root [ROOT_W+1];
  logic [SQS_W-1:0]   sq_side [ROOT_W+1];

  assign sq_rem[0]  = '0;
  assign sq_rad[0]  = s5_q;
  assign sq_root[0] = '0;
  assign sq_side[0] = {p5_q, d5_q, dd5_q, zero5_q};

  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    pgf_sqrt_cell #(.RW(ROOT_W), .SW(SQS_W)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  (sq_rem[i]),
      .rad_i  (sq_rad[i]),
      .root_i (sq_root[i]),
      .side_i (sq_side[i]),
      .rem_o  (sq_rem[i+1]),
      .rad_o  (sq_rad[i+1]),
      .root_o (sq_root[i+1]),
      .side_o (sq_side[i+1])
    );
  end

  // ---------------- magnitude divider: mag = P / (c << F), capped
  sq_side_t          sq_end;
  logic [W-1:0]      p_hi;
  logic [DEN_W-1:0]  md_rem  [MAG_W+1];
  logic [MAG_W-1:0]  md_num  [MAG_W+1];
  logic [MAG_W-1:0]  md_quo  [MAG_W+1];
  logic [DEN_W-1:0]  md_den  [MAG_W+1];
  logic [MGS_W-1:0]  md_side [MAG_W+1];

  assign sq_end     = sq_side[ROOT_W];
  assign p_hi       = sq_end.p[PROD_W-1:MAG_W];
  assign md_rem[0]  = DEN_W'(p_hi);
  assign md_num[0]  = sq_end.p[MAG_W-1:0];
  assign md_quo[0]  = '0;
  assign md_den[0]  = sq_end.d;
  // quotient would not fit in 2W bits, also covers a zero divisor
  assign md_side[0] = {sq_root[ROOT_W], sq_end.dd, sq_end.zero, DEN_W'(p_hi) >= sq_end.d};

  for (genvar i = 0; i < MAG_W; i++) begin : g_mag
    pgf_div_cell #(.DW(DEN_W), .QW(MAG_W), .SW(MGS_W)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  (md_rem[i]),
      .num_i  (md_num[i]),
      .quo_i  (md_quo[i]),
      .den_i  (md_den[i]),
      .side_i (md_side[i]),
      .rem_o  (md_rem[i+1]),
      .num_o  (md_num[i+1]),
      .quo_o  (md_quo[i+1]),
      .den_o  (md_den[i+1]),
      .side_o (md_side[i+1])
    );
  end

  // ---------------- mag * |d| products and overflow test
  mag_side_t         mg_end;
  logic [MAG_W-1:0]  mag;
  logic [MAG_W-1:0]  pxl_q, pxh_q, pyl_q, pyh_q;
  logic [PROD_W-1:0] nfx_q, nfy_q;
  logic [ROOT_W-1:0] len1_q, len2_q, len3_q;
  logic [2:0]        flg1_q, flg2_q;
  logic [HI_W-1:0]   hix, hiy;
  logic [ROOT_W-1:0] remx3_q, remy3_q;
  logic [FQ_W-1:0]   numx3_q, numy3_q;
  logic              nx3_q, ny3_q, zero3_q, ovfx3_q, ovfy3_q;

  assign mg_end = md_side[MAG_W];
  assign mag    = mg_end.movf ? '1 : md_quo[MAG_W];
  assign hix    = nfx_q[PROD_W-1:FQ_W];
  assign hiy    = nfy_q[PROD_W-1:FQ_W];

  always_ff @(posedge clk_i) begin
    if (en) begin
      pxl_q   <= mag[W-1:0] * mg_end.dd.ux;
      pxh_q   <= mag[MAG_W-1:W] * mg_end.dd.ux;
      pyl_q   <= mag[W-1:0] * mg_end.dd.uy;
      pyh_q   <= mag[MAG_W-1:W] * mg_end.dd.uy;
      len1_q  <= mg_end.len;
      flg1_q  <= {mg_end.dd.nx, mg_end.dd.ny, mg_end.zero};
      nfx_q   <= PROD_W'(pxl_q) + {pxh_q, {W{1'b0}}};
      nfy_q   <= PROD_W'(pyl_q) + {pyh_q, {W{1'b0}}};
      len2_q  <= len1_q;
      flg2_q  <= flg1_q;
      remx3_q <= hix[ROOT_W-1:0];
      remy3_q <= hiy[ROOT_W-1:0];
      numx3_q <= nfx_q[FQ_W-1:0];
      numy3_q <= nfy_q[FQ_W-1:0];
      ovfx3_q <= hix >= HI_W'(len2_q);
      ovfy3_q <= hiy >= HI_W'(len2_q);
      len3_q  <= len2_q;
      nx3_q   <= flg2_q[2];
      ny3_q   <= flg2_q[1];
      zero3_q <= flg2_q[0];
    end
  end

  // ---------------- component dividers: |f| = mag*|d| / len
  logic [ROOT_W-1:0] cx_rem [FQ_W+1], cy_rem [FQ_W+1];
  logic [FQ_W-1:0]   cx_num [FQ_W+1], cy_num [FQ_W+1];
  logic [FQ_W-1:0]   cx_quo [FQ_W+1], cy_quo [FQ_W+1];
  logic [ROOT_W-1:0] cx_den [FQ_W+1], cy_den [FQ_W+1];
  logic [2:0]        cx_side[FQ_W+1];
  logic [1:0]        cy_side[FQ_W+1];

  assign cx_rem[0]  = remx3_q;
  assign cx_num[0]  = numx3_q;
  assign cx_quo[0]  = '0;
  assign cx_den[0]  = len3_q;
  assign cx_side[0] = {nx3_q, ovfx3_q, zero3_q};
  assign cy_rem[0]  = remy3_q;
  assign cy_num[0]  = numy3_q;
  assign cy_quo[0]  = '0;
  assign cy_den[0]  = len3_q;
  assign cy_side[0] = {ny3_q, ovfy3_q};

  for (genvar i = 0; i < FQ_W; i++) begin : g_comp
    pgf_div_cell #(.DW(ROOT_W), .QW(FQ_W), .SW(3)) u_cell_x (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  (cx_rem[i]),
      .num_i  (cx_num[i]),
      .quo_i  (cx_quo[i]),
      .den_i  (cx_den[i]),
      .side_i (cx_side[i]),
      .rem_o  (cx_rem[i+1]),
      .num_o  (cx_num[i+1]),
      .quo_o  (cx_quo[i+1]),
      .den_o  (cx_den[i+1]),
      .side_o (cx_side[i+1])
    );
    pgf_div_cell #(.DW(ROOT_W), .QW(FQ_W), .SW(2)) u_cell_y (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  (cy_rem[i]),
      .num_i  (cy_num[i]),
      .quo_i  (cy_quo[i]),
      .den_i  (cy_den[i]),
      .side_i (cy_side[i]),
      .rem_o  (cy_rem[i+1]),
      .num_o  (cy_num[i+1]),
      .quo_o  (cy_quo[i+1]),
      .den_o  (cy_den[i+1]),
      .side_o (cy_side[i+1])
    );
  end

  // ---------------- sign, saturation
  // returns {saturated, value}
  function automatic logic [W:0] sat_comp(input logic [FQ_W-1:0] f, input logic neg,
                                          input logic ovf, input logic zero);
    logic [W:0] res;
    if (zero) begin
      res = '0;
    end else if (!neg) begin
      if (ovf || f > POS_LIM) res = {1'b1, POS_MAX};
      else                    res = {1'b0, f[W-1:0]};
    end else begin
      if (ovf || f > NEG_LIM) res = {1'b1, NEG_MIN};
      else                    res = {1'b0, W'(~f + 1'b1)};
    end
    return res;
  endfunction

  logic [W:0] rx, ry;
  force_t     res;
  logic [2:0] sx_end;
  logic [1:0] sy_end;

  always_comb begin
    sx_end        = cx_side[FQ_W];
    sy_end        = cy_side[FQ_W];
    rx            = sat_comp(cx_quo[FQ_W], sx_end[2], sx_end[1], sx_end[0]);
    ry            = sat_comp(cy_quo[FQ_W], sy_end[1], sy_end[0], sx_end[0]);
    res.force_x   = rx[W-1:0];
    res.force_y   = ry[W-1:0];
    res.saturated = rx[W] | ry[W];
  end

  // ---------------- two-word output buffer
  force_t     buf_q [2];
  logic       wr_q, rd_q;
  logic       push, pop;
  logic [1:0] cnt_d;

  assign push  = en & vld_q[LAT-1];
  assign pop   = out_o.valid & out_o.ready;
  assign cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_q] <= res;
  end

  assign out_o.valid   = (cnt_q != 2'd0);
  assign out_o.payload = buf_q[rd_q];

endmodule

// ----- rtl/core/pgf_div_cell.sv -----
// One restoring division step: shifts in a numerator bit and yields one quotient bit.
module pgf_div_cell #(
  parameter int DW = 48,
  parameter int QW = 64,
  parameter int SW = 8
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] num_i,
  input  logic [QW-1:0] quo_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic [DW-1:0] rem_o,
  output logic [QW-1:0] num_o,
  output logic [QW-1:0] quo_o,
  output logic [DW-1:0] den_o,
  output logic [SW-1:0] side_o
);

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_d;

  always_comb begin
    trial = {rem_i, num_i[QW-1]};
    diff  = trial - {1'b0, den_i};
    ge    = trial >= {1'b0, den_i};
    rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      num_o  <= {num_i[QW-2:0], 1'b0};
      quo_o  <= {quo_i[QW-2:0], ge};
      den_o  <= den_i;
      side_o <= side_i;
    end
  end

endmodule

// ----- rtl/core/pgf_sqrt_cell.sv -----
// One digit-by-digit square root step: takes two radicand bits, yields one root bit.
module pgf_sqrt_cell #(
  parameter int RW = 33,
  parameter int SW = 8
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [RW+1:0]   rem_i,
  input  logic [2*RW-1:0] rad_i,
  input  logic [RW-1:0]   root_i,
  input  logic [SW-1:0]   side_i,
  output logic [RW+1:0]   rem_o,
  output logic [2*RW-1:0] rad_o,
  output logic [RW-1:0]   root_o,
  output logic [SW-1:0]   side_o
);

  logic [RW+3:0] cur;
  logic [RW+3:0] trial;
  logic [RW+3:0] diff;
  logic          ge;

  always_comb begin
    cur   = {rem_i, rad_i[2*RW-1 -: 2]};
    trial = {2'b00, root_i, 2'b01};
    diff  = cur - trial;
    ge    = cur >= trial;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= ge ? diff[RW+1:0] : cur[RW+1:0];
      rad_o  <= {rad_i[2*RW-3:0], 2'b00};
      root_o <= {root_i[RW-2:0], ge};
      side_o <= side_i;
    end
  end

endmodule

// ----- dv/tb.sv -----
// Testbench for the pairwise gravity force block: directed and random pairs checked against a predictor.
`timescale 1ns / 100ps

module tb;
  import pgf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 160;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_ITEMS = 1000;
  localparam logic [WORD_WIDTH-1:0] WORD_MAX = '1;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [WORD_WIDTH-1:0] cfg_data_i;

  pgf_in_if  in_if ();
  pgf_out_if out_if ();

  pairwise_gravity_force dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if.sink),
    .out_o      (out_if.source)
  );

  // predictor copy of the registers
  logic [WORD_WIDTH-1:0] g_const;
  logic [WORD_WIDTH-1:0] dsq_floor;
  logic [WORD_WIDTH-1:0] dsq_ceil;

  force_t force_q[$];
  int     errors;
  int     cycles;
  int     burst_left;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver stall pattern: a randomly chosen mode holds until its counter runs out
  int stall_mode;
  int mode_cnt;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_mode   <= 0;
      mode_cnt     <= 0;
    end else begin
      if (mode_cnt == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_cnt   <= $urandom_range(50, 400);
      end else begin
        mode_cnt <= mode_cnt - 1;
      end
      case (stall_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 1) == 1);
        2: out_if.ready <= ($urandom_range(0, 7) == 0);
        default: out_if.ready <= (mode_cnt[4:0] < 5'd24);
      endcase
    end
  end

  always @(posedge clk_i) begin
    force_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (force_q.size() == 0) begin
        $error("force word with none expected: %h", out_if.payload);
        errors++;
      end else begin
        want = force_q.pop_front();
        if (out_if.payload.force_x !== want.force_x) begin
          $error("force_x expected %h actual %h", want.force_x, out_if.payload.force_x);
          errors++;
        end
        if (out_if.payload.force_y !== want.force_y) begin
          $error("force_y expected %h actual %h", want.force_y, out_if.payload.force_y);
          errors++;
        end
        if (out_if.payload.saturated !== want.saturated) begin
          $error("saturated expected %b actual %b", want.saturated,
                 out_if.payload.saturated);
          errors++;
        end
      end
    end
  end

  function automatic logic [WORD_WIDTH-1:0] scale_component(
      logic [127:0] mag, logic [32:0] u, logic neg, logic [127:0] len, inout logic sat);
    logic [127:0] f;
    f = (u == 0) ? 128'd0 : (mag * u) / len;
    if (!neg) begin
      if (f > 128'h7fff_ffff) begin
        f = 128'h7fff_ffff;
        sat = 1'b1;
      end
    end else begin
      if (f > 128'h8000_0000) begin
        f = 128'h8000_0000;
        sat = 1'b1;
      end
      f = -f;
    end
    return f[WORD_WIDTH-1:0];
  endfunction

  function automatic force_t gravity_force(pair_t p);
    logic signed [32:0] ddx, ddy;
    logic [32:0] ux, uy;
    logic nx, ny, sat;
    logic [127:0] s, dsq, c, len, t, prod, mag;
    force_t r;
    ddx = $signed({p.second_pos_x[31], p.second_pos_x})
        - $signed({p.first_pos_x[31], p.first_pos_x});
    ddy = $signed({p.second_pos_y[31], p.second_pos_y})
        - $signed({p.first_pos_y[31], p.first_pos_y});
    nx = ddx < 0;
    ny = ddy < 0;
    ux = nx ? -ddx : ddx;
    uy = ny ? -ddy : ddy;
    s = 128'(ux) * 128'(ux) + 128'(uy) * 128'(uy);
    r = '0;
    if (s == 0) return r;
    dsq = s >> FRAC_BITS;
    if (dsq < dsq_floor) c = dsq_floor;
    else if (dsq > dsq_ceil) c = dsq_ceil;
    else c = dsq;
    len = 0;
    for (int i = 63; i >= 0; i--) begin
      t = len | (128'd1 << i);
      if (t * t <= s) len = t;
    end
    prod = 128'(p.first_mass) * 128'(p.second_mass) * 128'(g_const);
    if (c == 0) begin
      mag = {64'd0, {64{1'b1}}};
    end else begin
      mag = prod / (c << FRAC_BITS);
      if (mag[127:64] != 0) mag = {64'd0, {64{1'b1}}};
    end
    sat = 1'b0;
    r.force_x = scale_component(mag, ux, nx, len, sat);
    r.force_y = scale_component(mag, uy, ny, len, sat);
    r.saturated = sat;
    return r;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_WIDTH-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_GRAVITY: g_const   = data;
      REG_MIN_DSQ: dsq_floor = data;
      REG_MAX_DSQ: dsq_ceil  = data;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (force_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_clamp(logic [WORD_WIDTH-1:0] g, logic [WORD_WIDTH-1:0] lo,
                           logic [WORD_WIDTH-1:0] hi);
    wait_idle();
    write_reg(REG_GRAVITY, g);
    write_reg(REG_MIN_DSQ, lo);
    write_reg(REG_MAX_DSQ, hi);
  endtask

  // sender works in bursts; valid stays high across words within a burst
  task automatic send_pair(pair_t p);
    in_if.valid   <= 1'b1;
    in_if.payload <= p;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    force_q.push_back(gravity_force(p));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      if ($urandom_range(0, 2) != 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  endtask

  function automatic pair_t make_pair(logic signed [31:0] x1, logic signed [31:0] y1,
      logic signed [31:0] x2, logic signed [31:0] y2,
      logic [31:0] m1, logic [31:0] m2);
    pair_t p;
    p.first_pos_x  = x1;
    p.first_pos_y  = y1;
    p.second_pos_x = x2;
    p.second_pos_y = y2;
    p.first_mass   = m1;
    p.second_mass  = m2;
    return p;
  endfunction

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
      2: return $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
      default: return $urandom_range(0, 32'h0000_0fff) - 32'h0000_0800;
    endcase
  endfunction

  function automatic logic [31:0] rand_mass();
    case ($urandom_range(0, 2))
      0: return $urandom;
      1: return $urandom_range(0, 32'h00ff_ffff);
      default: return $urandom_range(0, 32'h0004_0000);
    endcase
  endfunction

  task automatic test_defaults();
    send_pair(make_pair(0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000));
    send_pair(make_pair(32'sh1234_0000, -5, 32'sh1234_0000, -5, WORD_MAX, WORD_MAX));
    send_pair(make_pair(0, 0, 32'sh0001_0000, 0, 32'h0001_0000, 32'h0001_0000));
    send_pair(make_pair(0, 0, 0, -32'sh0002_0000, 32'h0003_0000, 32'h0001_8000));
    send_pair(make_pair(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
                        32'sh7fff_ffff, WORD_MAX, WORD_MAX));
    send_pair(make_pair(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000,
                        32'sh8000_0000, 1, 1));
    send_pair(make_pair(0, 0, 1, 1, WORD_MAX, WORD_MAX));
    send_pair(make_pair(0, 0, -1, 0, 0, WORD_MAX));
    send_pair(make_pair(32'sh0003_0000, 32'sh0004_0000, 0, 0, 32'h0010_0000,
                        32'h0010_0000));
  endtask

  task automatic test_clamp_extremes();
    // zero lower clamp with a tiny distance: magnitude hits its cap
    set_clamp(32'h0001_0000, 0, WORD_MAX);
    send_pair(make_pair(0, 0, 1, 0, 32'h0001_0000, 32'h0001_0000));
    send_pair(make_pair(0, 0, 0, -1, 1, 1));
    send_pair(make_pair(5, 5, 5, 5, 1, 1));
    // inverted clamp: lower bound wins below it, upper bound above it
    set_clamp(WORD_MAX, 32'h0010_0000, 32'h0000_1000);
    send_pair(make_pair(0, 0, 32'sh0000_1000, 0, 32'h0001_0000, 32'h0001_0000));
    send_pair(make_pair(0, 0, 32'sh0100_0000, 32'sh0100_0000, 32'h0001_0000,
                        32'h0001_0000));
    // zero gravity and zero upper clamp
    set_clamp(0, 0, 0);
    send_pair(make_pair(0, 0, 32'sh0005_0000, 0, WORD_MAX, WORD_MAX));
    send_pair(make_pair(0, 0, 0, 0, WORD_MAX, WORD_MAX));
    set_clamp(1, 1, 2);
    send_pair(make_pair(0, 0, 32'sh0005_0000, -32'sh0003_0000, WORD_MAX, WORD_MAX));
    send_pair(make_pair(-3, 7, 9, -2, 32'h0002_0000, 32'h0000_0100));
    // unused index leaves every register alone
    wait_idle();
    write_reg(REG_UNUSED, 32'hdead_beef);
    send_pair(make_pair(0, 0, 32'sh0001_0000, 32'sh0001_0000, 32'h0001_0000,
                        32'h0001_0000));
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_clamp(32'h0001_0000, 32'h0001_0000, WORD_MAX);
        1: set_clamp(WORD_MAX, 0, WORD_MAX);
        2: set_clamp(0, WORD_MAX, WORD_MAX);
        default: set_clamp($urandom_range(0, 32'h0010_0000), $urandom_range(0, 32'h0004_0000),
                           $urandom);
      endcase
      for (int n = 0; n < RANDOM_ITEMS / 8; n++) begin
        if (n == RANDOM_ITEMS / 16) begin
          // hold off until the pipeline has emptied
          in_if.valid <= 1'b0;
          while (force_q.size() != 0) @(posedge clk_i);
        end
        send_pair(make_pair(rand_pos(), rand_pos(), rand_pos(), rand_pos(),
                            rand_mass(), rand_mass()));
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_GRAVITY;
    cfg_data_i    = '0;
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    errors        = 0;
    cycles        = 0;
    burst_left    = 0;
    g_const       = ONE_FIX;
    dsq_floor     = ONE_FIX;
    dsq_ceil      = WORD_MAX;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_clamp_extremes();
    test_random();
    in_if.valid <= 1'b0;
    wait_idle();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
